### sv/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Depends on clk and rst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock, skipped while reset is held.
`define ODUR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock, including during reset.
`define ODUR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ODUR_ASSERT(lbl, prop, msg)
`define ODUR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### sv/odur_pkg.sv
// Shared types and constants of the dual-pin oversampled UART receiver.
// No dependencies.
package odur_pkg;

  localparam int BUFFER_DEPTH_DEF = 32;
  localparam int BITS_PER_CHAR    = 9;

  localparam logic [2:0] START_WAIT    = 3'd4;
  localparam logic [2:0] TICKS_PER_BIT = 3'd3;
  localparam logic [7:0] TIMEOUT_RESET = 8'd105;
  localparam logic [3:0] CHAR_BITS     = 4'(BITS_PER_CHAR);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    PIN_NONE = 2'd0,
    PIN_A    = 2'd1,
    PIN_B    = 2'd2
  } pin_sel_t;

  typedef struct packed {
    logic command;
    logic pin_a_level;
    logic pin_b_level;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [4:0] byte_index;
    logic       frame_done;
    logic       receiving;
  } result_t;

endpackage

### sv/odur_in_if.sv
// Input channel of the receiver: one beat per sample tick or clear command.
// Depends on nothing.
interface odur_in_if;
  logic valid;
  logic ready;
  logic command;
  logic pin_a_level;
  logic pin_b_level;

  modport source (output valid, output command, output pin_a_level, output pin_b_level,
                  input ready);
  modport sink (input valid, input command, input pin_a_level, input pin_b_level,
                output ready);
endinterface

### sv/odur_out_if.sv
// Result channel of the receiver: one beat per input beat.
// Depends on nothing.
interface odur_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [4:0] byte_index;
  logic       frame_done;
  logic       receiving;

  modport source (output valid, output byte_valid, output byte_value, output byte_index,
                  output frame_done, output receiving, input ready);
  modport sink (input valid, input byte_valid, input byte_value, input byte_index,
                input frame_done, input receiving, output ready);
endinterface

### sv/odur_core.sv
// Receiver state and single-pass step logic for one beat.
// Depends on odur_pkg and assert_macros.svh.
`include "assert_macros.svh"

module odur_core #(
  parameter int BUFFER_DEPTH = odur_pkg::BUFFER_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  odur_pkg::in_item_t item,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  output odur_pkg::result_t  res
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic               busy_r, busy_nxt;
  logic [2:0]         sample_r, sample_nxt;
  logic [3:0]         bits_r, bits_nxt;
  logic [7:0]         shift_r, shift_nxt;
  odur_pkg::pin_sel_t pin_r, pin_nxt;
  logic [7:0]         tmo_r, tmo_nxt;
  logic               done_r, done_nxt;
  logic [IDX_W-1:0]   widx_r, widx_nxt;
  logic [7:0]         idle_ticks_r;

  logic [2:0]         sample_dec;
  logic [3:0]         bits_dec;
  logic [IDX_W:0]     widx_inc;
  logic [7:0]         tmo_base;
  logic               line_bit;
  logic               accept;

  always_comb begin
    case (pin_r)
      odur_pkg::PIN_A: line_bit = item.pin_a_level;
      odur_pkg::PIN_B: line_bit = item.pin_b_level;
      default:         line_bit = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    sample_nxt = sample_r;
    bits_nxt   = bits_r;
    shift_nxt  = shift_r;
    pin_nxt    = pin_r;
    tmo_nxt    = tmo_r;
    done_nxt   = done_r;
    widx_nxt   = widx_r;
    accept     = 1'b0;
    sample_dec = sample_r - 3'd1;
    bits_dec   = bits_r - 4'd1;
    widx_inc   = {1'b0, widx_r} + (IDX_W + 1)'(1);
    tmo_base   = tmo_r;

    if (item.command == odur_pkg::CMD_CLEAR) begin
      done_nxt = 1'b0;
      widx_nxt = '0;
    end else begin
      if (busy_r) begin
        if (sample_dec == 3'd0) begin
          sample_nxt = odur_pkg::TICKS_PER_BIT;
          bits_nxt   = bits_dec;
          if (bits_dec == 4'd0) begin
            busy_nxt = 1'b0;
            if ((item.pin_a_level | item.pin_b_level) && !done_r) begin
              accept   = 1'b1;
              tmo_base = idle_ticks_r;
              widx_nxt = (widx_inc >= (IDX_W + 1)'(BUFFER_DEPTH)) ? '0 : widx_inc[IDX_W-1:0];
            end
          end else begin
            shift_nxt = {line_bit, shift_r[7:1]};
          end
        end else begin
          sample_nxt = sample_dec;
        end
      end else if (!item.pin_b_level) begin
        pin_nxt    = odur_pkg::PIN_B;
        busy_nxt   = 1'b1;
        sample_nxt = odur_pkg::START_WAIT;
        bits_nxt   = odur_pkg::CHAR_BITS;
      end else if (!item.pin_a_level) begin
        pin_nxt    = odur_pkg::PIN_A;
        busy_nxt   = 1'b1;
        sample_nxt = odur_pkg::START_WAIT;
        bits_nxt   = odur_pkg::CHAR_BITS;
      end

      tmo_nxt = tmo_base;
      if (tmo_base != 8'd0) begin
        tmo_nxt = tmo_base - 8'd1;
        if (tmo_base == 8'd1) begin
          done_nxt = 1'b1;
        end
      end
    end

    res.byte_valid = accept;
    res.byte_value = accept ? shift_r : 8'd0;
    res.byte_index = accept ? 5'(widx_r) : 5'd0;
    res.frame_done = done_nxt;
    res.receiving  = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      sample_r     <= odur_pkg::START_WAIT;
      bits_r       <= 4'd0;
      shift_r      <= 8'd0;
      pin_r        <= odur_pkg::PIN_NONE;
      tmo_r        <= 8'd0;
      done_r       <= 1'b0;
      widx_r       <= '0;
      idle_ticks_r <= odur_pkg::TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        idle_ticks_r <= cfg_wdata;
      end
      if (step) begin
        busy_r   <= busy_nxt;
        sample_r <= sample_nxt;
        bits_r   <= bits_nxt;
        shift_r  <= shift_nxt;
        pin_r    <= pin_nxt;
        tmo_r    <= tmo_nxt;
        done_r   <= done_nxt;
        widx_r   <= widx_nxt;
      end
    end
  end

  `ODUR_ASSERT(a_byte_needs_busy, step && res.byte_valid |-> busy_r && !done_r, "stray byte")
  `ODUR_ASSERT(a_sample_nonzero, busy_r |-> sample_r != 3'd0, "sample count zero while busy")
  `ODUR_ASSERT(a_index_range, (IDX_W + 1)'(widx_r) < (IDX_W + 1)'(BUFFER_DEPTH), "index past depth")
  `ODUR_ASSERT(a_timer_runs, step && item.command == odur_pkg::CMD_TICK && !res.byte_valid && tmo_r > 8'd1 |=> tmo_r == $past(tmo_r) - 8'd1, "timer stuck")

endmodule

### sv/oversampled_dual_pin_uart_receiver.sv
// Dual-pin UART receiver at three sample ticks per bit: one beat in per cycle while the result
// side is not stalled, one result beat out per input beat. Each beat is held in an input
// register, run through the receiver step in one pass and held in the result register; a
// stalled result lets the input register take one more beat, then holds off further input.
// Depends on odur_pkg, odur_in_if, odur_out_if and odur_core.
module oversampled_dual_pin_uart_receiver #(
  parameter int BUFFER_DEPTH = odur_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  odur_in_if.sink    in_if,
  odur_out_if.source out_if,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic               s1_vld_r;
  odur_pkg::in_item_t s1_item_r;
  logic               out_vld_r;
  odur_pkg::result_t  out_res_r;
  odur_pkg::result_t  step_res;
  logic               advance;

  assign advance     = s1_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_vld_r <= in_if.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_item_r.command     <= in_if.command;
      s1_item_r.pin_a_level <= in_if.pin_a_level;
      s1_item_r.pin_b_level <= in_if.pin_b_level;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  odur_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (s1_item_r),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .res      (step_res)
  );

  assign out_if.valid      = out_vld_r;
  assign out_if.byte_valid = out_res_r.byte_valid;
  assign out_if.byte_value = out_res_r.byte_value;
  assign out_if.byte_index = out_res_r.byte_index;
  assign out_if.frame_done = out_res_r.frame_done;
  assign out_if.receiving  = out_res_r.receiving;

endmodule

### dv/tb.sv
// Testbench for the dual-pin oversampled UART receiver: sends tick and clear beats, predicts
// every result beat and checks each one as it comes out.
// Depends on odur_pkg, odur_in_if, odur_out_if and oversampled_dual_pin_uart_receiver.
`timescale 1ns / 100ps

module tb;

  localparam int OTHER_HIGH         = 0;
  localparam int OTHER_LOW_AT_START = 1;
  localparam int OTHER_NOISE        = 2;
  localparam int CHAR_TICKS         = 30;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  odur_in_if  in_ch ();
  odur_out_if out_ch ();

  oversampled_dual_pin_uart_receiver #(
    .BUFFER_DEPTH(odur_pkg::BUFFER_DEPTH_DEF)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Receiver state as predicted from the accepted beats.
  logic               rx_busy;
  logic [2:0]         rx_sample_count;
  logic [3:0]         rx_bits_left;
  logic [7:0]         rx_shift;
  odur_pkg::pin_sel_t rx_pin;
  logic [7:0]         rx_idle_timer;
  logic               rx_done;
  int                 rx_index;
  logic [7:0]         idle_timeout_reg;
  int                 bytes_since_clear;

  odur_pkg::result_t  pending_results[$];
  int                 error_count;
  int                 burst_left;
  int                 hold_off_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic reset_rx_model();
    rx_busy           = 1'b0;
    rx_sample_count   = odur_pkg::START_WAIT;
    rx_bits_left      = '0;
    rx_shift          = '0;
    rx_pin            = odur_pkg::PIN_NONE;
    rx_idle_timer     = '0;
    rx_done           = 1'b0;
    rx_index          = 0;
    idle_timeout_reg  = odur_pkg::TIMEOUT_RESET;
    bytes_since_clear = 0;
  endtask

  function automatic odur_pkg::result_t predict_rx(input odur_pkg::in_item_t it);
    odur_pkg::result_t r;
    logic              data_bit;
    r = '0;
    if (it.command == odur_pkg::CMD_CLEAR) begin
      rx_done           = 1'b0;
      rx_index          = 0;
      bytes_since_clear = 0;
    end else begin
      if (rx_busy) begin
        rx_sample_count = rx_sample_count - 3'd1;
        if (rx_sample_count == 3'd0) begin
          rx_sample_count = odur_pkg::TICKS_PER_BIT;
          rx_bits_left    = rx_bits_left - 4'd1;
          if (rx_bits_left == 4'd0) begin
            rx_busy = 1'b0;
            if ((it.pin_a_level | it.pin_b_level) && !rx_done) begin
              r.byte_valid  = 1'b1;
              r.byte_value  = rx_shift;
              r.byte_index  = 5'(rx_index);
              rx_index      = (rx_index + 1 >= odur_pkg::BUFFER_DEPTH_DEF) ? 0 : rx_index + 1;
              rx_idle_timer = idle_timeout_reg;
              bytes_since_clear++;
            end
          end else begin
            data_bit = (rx_pin == odur_pkg::PIN_A) ? it.pin_a_level :
                       (rx_pin == odur_pkg::PIN_B) ? it.pin_b_level : 1'b0;
            rx_shift = {data_bit, rx_shift[7:1]};
          end
        end
      end else if (!it.pin_b_level) begin
        rx_pin          = odur_pkg::PIN_B;
        rx_busy         = 1'b1;
        rx_sample_count = odur_pkg::START_WAIT;
        rx_bits_left    = odur_pkg::CHAR_BITS;
      end else if (!it.pin_a_level) begin
        rx_pin          = odur_pkg::PIN_A;
        rx_busy         = 1'b1;
        rx_sample_count = odur_pkg::START_WAIT;
        rx_bits_left    = odur_pkg::CHAR_BITS;
      end
      if (rx_idle_timer != 8'd0) begin
        rx_idle_timer = rx_idle_timer - 8'd1;
        if (rx_idle_timer == 8'd0) rx_done = 1'b1;
      end
    end
    r.frame_done = rx_done;
    r.receiving  = rx_busy;
    return r;
  endfunction

  task automatic report_failure(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] gotv);
    if (gotv !== expv)
      report_failure($sformatf("%s expected 0x%0h got 0x%0h", name, expv, gotv));
  endtask

  task automatic check_result();
    odur_pkg::result_t exp_r;
    if (pending_results.size() == 0) begin
      report_failure("result beat with nothing pending");
    end else begin
      exp_r = pending_results.pop_front();
      check_field("byte_valid", 8'(exp_r.byte_valid), 8'(out_ch.byte_valid));
      check_field("byte_value", exp_r.byte_value, out_ch.byte_value);
      check_field("byte_index", 8'(exp_r.byte_index), 8'(out_ch.byte_index));
      check_field("frame_done", 8'(exp_r.frame_done), 8'(out_ch.frame_done));
      check_field("receiving", 8'(exp_r.receiving), 8'(out_ch.receiving));
    end
  endtask

  // Result side: check each beat, then pick the next ready level.
  initial begin
    int phase_cycles;
    int stall_mode;
    phase_cycles = 0;
    stall_mode   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result();
      if (phase_cycles == 0) begin
        stall_mode   = $urandom_range(0, 3);
        phase_cycles = $urandom_range(16, 96);
      end
      phase_cycles--;
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(input odur_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= it.command;
    in_ch.pin_a_level <= it.pin_a_level;
    in_ch.pin_b_level <= it.pin_b_level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    pending_results.push_back(predict_rx(it));
  endtask

  task automatic send_clear();
    odur_pkg::in_item_t it;
    it.command     = odur_pkg::CMD_CLEAR;
    it.pin_a_level = 1'($urandom_range(0, 1));
    it.pin_b_level = 1'($urandom_range(0, 1));
    send_beat(it);
  endtask

  task automatic send_noise(input int count);
    odur_pkg::in_item_t it;
    repeat (count) begin
      it.command     = ($urandom_range(0, 7) == 0) ? odur_pkg::CMD_CLEAR : odur_pkg::CMD_TICK;
      it.pin_a_level = 1'($urandom_range(0, 1));
      it.pin_b_level = 1'($urandom_range(0, 1));
      send_beat(it);
    end
  endtask

  // One character on the chosen pin: start, eight data bits LSB first, stop, then idle high.
  task automatic send_char(input odur_pkg::pin_sel_t pin, input logic [7:0] value,
                           input logic stop_level, input int other_mode, input int idle_ticks);
    odur_pkg::in_item_t it;
    logic               line;
    logic               other;
    for (int i = 0; i < CHAR_TICKS + idle_ticks; i++) begin
      if (i < 3) line = 1'b0;
      else if (i < 27) line = value[(i - 3) / 3];
      else if (i < CHAR_TICKS) line = stop_level;
      else line = 1'b1;
      case (other_mode)
        OTHER_HIGH:         other = 1'b1;
        OTHER_LOW_AT_START: other = (i >= 3);
        default:            other = ($urandom_range(0, 15) != 0);
      endcase
      it.command     = odur_pkg::CMD_TICK;
      it.pin_a_level = (pin == odur_pkg::PIN_A) ? line : other;
      it.pin_b_level = (pin == odur_pkg::PIN_B) ? line : other;
      send_beat(it);
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_idle_timeout(input logic [7:0] ticks);
    wait_all_results();
    cfg_wdata <= ticks;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_timeout_reg = ticks;
  endtask

  function automatic odur_pkg::pin_sel_t random_pin();
    return ($urandom_range(0, 1) != 0) ? odur_pkg::PIN_A : odur_pkg::PIN_B;
  endfunction

  task automatic test_basic_beats();
    odur_pkg::in_item_t it;
    it = '{command: odur_pkg::CMD_CLEAR, pin_a_level: 1'b0, pin_b_level: 1'b0};
    send_beat(it);
    it = '{command: odur_pkg::CMD_TICK, pin_a_level: 1'b1, pin_b_level: 1'b1};
    send_beat(it);
    it = '{command: odur_pkg::CMD_CLEAR, pin_a_level: 1'b1, pin_b_level: 1'b1};
    send_beat(it);
    send_char(odur_pkg::PIN_B, 8'h5A, 1'b1, OTHER_LOW_AT_START, 2);
  endtask

  task automatic test_idle_timeout_limits();
    set_idle_timeout(8'd1);
    send_char(odur_pkg::PIN_A, 8'hFF, 1'b1, OTHER_HIGH, 2);
    send_char(odur_pkg::PIN_B, 8'h00, 1'b1, OTHER_HIGH, 1);
    send_clear();
    set_idle_timeout(8'd0);
    send_char(odur_pkg::PIN_B, 8'h00, 1'b1, OTHER_HIGH, 3);
    set_idle_timeout(8'd255);
    send_char(odur_pkg::PIN_A, 8'h80, 1'b1, OTHER_HIGH, 3);
  endtask

  task automatic test_stop_and_pending();
    set_idle_timeout(8'd4);
    send_char(odur_pkg::PIN_B, 8'h3C, 1'b0, OTHER_HIGH, 30);
    send_char(odur_pkg::PIN_A, 8'hC3, 1'b1, OTHER_HIGH, 8);
    send_char(odur_pkg::PIN_B, 8'h11, 1'b1, OTHER_HIGH, 2);
    send_clear();
    send_char(odur_pkg::PIN_A, 8'h22, 1'b1, OTHER_HIGH, 2);
    send_clear();
  endtask

  task automatic test_backpressure();
    hold_off_left = 150;
    send_char(random_pin(), 8'($urandom_range(0, 255)), 1'b1, OTHER_HIGH, 10);
    wait_all_results();
  endtask

  task automatic test_index_wrap();
    set_idle_timeout(8'd255);
    send_clear();
    while (bytes_since_clear < odur_pkg::BUFFER_DEPTH_DEF + 2)
      send_char(random_pin(), 8'($urandom_range(0, 255)), 1'b1,
                ($urandom_range(0, 3) == 0) ? OTHER_LOW_AT_START : OTHER_HIGH,
                $urandom_range(0, 1));
  endtask

  task automatic test_random_traffic();
    logic [7:0] ticks;
    int         sent;
    int         pick;
    for (int p = 0; p < 3; p++) begin
      ticks = (p == 0) ? 8'($urandom_range(2, 30)) :
              (p == 1) ? odur_pkg::TIMEOUT_RESET : 8'd6;
      set_idle_timeout(ticks);
      sent = 0;
      while (sent < 30) begin
        pick = $urandom_range(0, 19);
        if (rx_done && $urandom_range(0, 1) != 0) begin
          send_clear();
          sent++;
        end else if (pick < 14) begin
          send_char(random_pin(), 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 9) != 0),
                    (pick < 10) ? OTHER_HIGH : (pick < 12) ? OTHER_LOW_AT_START : OTHER_NOISE,
                    ($urandom_range(0, 3) == 0) ? int'(ticks) + $urandom_range(0, 4) :
                                                  $urandom_range(0, 8));
          sent += CHAR_TICKS;
        end else if (pick < 18) begin
          send_noise($urandom_range(1, 6));
          sent += 3;
        end else begin
          send_clear();
          sent++;
        end
      end
    end
  endtask

  initial begin
    error_count   = 0;
    burst_left    = 0;
    hold_off_left = 0;
    reset_rx_model();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= odur_pkg::CMD_TICK;
    in_ch.pin_a_level <= 1'b1;
    in_ch.pin_b_level <= 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_beats();
    test_idle_timeout_limits();
    test_stop_and_pending();
    test_backpressure();
    test_index_wrap();
    test_random_traffic();

    wait_all_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_failure("results still pending at end of run");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
